/* design/ecvs_pkg.sv */
package ecvs_pkg;

  localparam int NUM_FRAMES      = 512;
  localparam int FRAME_W         = $clog2(NUM_FRAMES);
  localparam int COUNT_W         = $clog2(NUM_FRAMES + 1);
  localparam int OWNER_W         = 8;
  localparam int PAGE_W          = 20;
  localparam int FRAME_COUNT_RST = 367;

  // request opcodes
  typedef enum logic [1:0] {
    OP_MAP    = 2'd0,
    OP_UNMAP  = 2'd1,
    OP_REF    = 2'd2,
    OP_SELECT = 2'd3
  } op_t;

  // write request into the frame table; each field group has its own enable
  typedef struct packed {
    logic [FRAME_W-1:0] addr;
    logic               used_we;
    logic               used_d;
    logic               acc_we;
    logic               acc_d;
    logic               dirty_we;
    logic               dirty_d;
    logic               pay_we;
    logic [OWNER_W-1:0] owner;
    logic [PAGE_W-1:0]  page;
  } tbl_wr_t;

  // registered read data of one frame
  typedef struct packed {
    logic               used;
    logic               acc;
    logic               dirty;
    logic [OWNER_W-1:0] owner;
    logic [PAGE_W-1:0]  page;
  } tbl_rd_t;

endpackage

/* design/ecvs_frame_table.sv */
module ecvs_frame_table (
  input  logic                            clk,
  input  ecvs_pkg::tbl_wr_t               wr_i,
  input  logic [ecvs_pkg::FRAME_W-1:0]    rd_addr_i,
  output ecvs_pkg::tbl_rd_t               rd_o
);
  import ecvs_pkg::*;

  logic               used_mem  [NUM_FRAMES];
  logic               acc_mem   [NUM_FRAMES];
  logic               dirty_mem [NUM_FRAMES];
  logic [OWNER_W-1:0] owner_mem [NUM_FRAMES];
  logic [PAGE_W-1:0]  page_mem  [NUM_FRAMES];

  always_ff @(posedge clk) begin
    if (wr_i.used_we) begin
      used_mem[wr_i.addr] <= wr_i.used_d;
    end
    if (wr_i.acc_we) begin
      acc_mem[wr_i.addr] <= wr_i.acc_d;
    end
    if (wr_i.dirty_we) begin
      dirty_mem[wr_i.addr] <= wr_i.dirty_d;
    end
    if (wr_i.pay_we) begin
      owner_mem[wr_i.addr] <= wr_i.owner;
      page_mem[wr_i.addr]  <= wr_i.page;
    end
  end

  // one read port, data registered
  always_ff @(posedge clk) begin
    rd_o.used  <= used_mem[rd_addr_i];
    rd_o.acc   <= acc_mem[rd_addr_i];
    rd_o.dirty <= dirty_mem[rd_addr_i];
    rd_o.owner <= owner_mem[rd_addr_i];
    rd_o.page  <= page_mem[rd_addr_i];
  end

endmodule

/* design/enhanced_clock_victim_select_unit.sv */
// Map/unmap write one frame per cycle, clipped at the last frame. Select does one scan
// read per cycle through the table port over the configured frames, then one
// accessed-clear write per cycle.
// Throughput: one request in flight; the next is taken once the result sits in the output
// register. Reset is synchronous, active low; after reset a pass over all 512 frames clears the
// used/accessed/dirty marks, and no request is taken until it ends.
module enhanced_clock_victim_select_unit (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: frame_count
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // frame_index[8:0], page_count[18:9], owner_id[26:19],
                                  // user_page[46:27], zero pad[47]
  input  logic [2:0]  in_tuser,   // opcode[1:0], is_write[2]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // victim_frame[8:0], victim_owner[16:9],
                                  // victim_page[36:17], victim_dirty[37], zero pad[39:38]
  output logic [0:0]  out_tuser   // victim_found[0]
);
  import ecvs_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_REF,
    ST_SCAN,
    ST_SWEEP,
    ST_RESP
  } state_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] frame_count_r, frame_count_nxt;
  logic [FRAME_W-1:0] hand_r, hand_nxt;

  op_t                op_r, op_nxt;
  logic [OWNER_W-1:0] owner_r, owner_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic               wr_r, wr_nxt;

  // walking address (clear, run, scan, sweep) and step count (run, scan, sweep)
  logic [FRAME_W-1:0] addr_r, addr_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [COUNT_W-1:0] n_r, n_nxt;
  logic [FRAME_W-1:0] start_r, start_nxt;

  // scan pipeline tag: address whose table data arrives this cycle
  logic               tag_vld_r, tag_vld_nxt;
  logic [FRAME_W-1:0] tag_addr_r, tag_addr_nxt;

  // second-pass candidate: first used, unaccessed frame from the hand
  logic               c2_vld_r, c2_vld_nxt;
  logic [FRAME_W-1:0] c2_frame_r, c2_frame_nxt;
  logic [OWNER_W-1:0] c2_owner_r, c2_owner_nxt;
  logic [PAGE_W-1:0]  c2_page_r, c2_page_nxt;
  logic               c2_dirty_r, c2_dirty_nxt;

  // fallback candidate: first used frame from the hand
  logic               c3_vld_r, c3_vld_nxt;
  logic [FRAME_W-1:0] c3_frame_r, c3_frame_nxt;
  logic [OWNER_W-1:0] c3_owner_r, c3_owner_nxt;
  logic [PAGE_W-1:0]  c3_page_r, c3_page_nxt;
  logic               c3_dirty_r, c3_dirty_nxt;

  // finished result waiting for the output register
  logic               res_found_r, res_found_nxt;
  logic [FRAME_W-1:0] res_frame_r, res_frame_nxt;
  logic [OWNER_W-1:0] res_owner_r, res_owner_nxt;
  logic [PAGE_W-1:0]  res_page_r, res_page_nxt;
  logic               res_dirty_r, res_dirty_nxt;

  logic               out_vld_r, out_vld_nxt;
  logic [39:0]        out_data_r, out_data_nxt;
  logic               out_user_r, out_user_nxt;

  // ---------------------------------------------------------------------------
  // Frame table
  // ---------------------------------------------------------------------------
  tbl_wr_t            tbl_wr;
  tbl_rd_t            tbl_rd;
  logic [FRAME_W-1:0] rd_addr;

  ecvs_frame_table u_table (
    .clk       (clk),
    .wr_i      (tbl_wr),
    .rd_addr_i (rd_addr),
    .rd_o      (tbl_rd)
  );

  // ---------------------------------------------------------------------------
  // Request fields
  // ---------------------------------------------------------------------------
  logic [FRAME_W-1:0] in_frame;
  logic [COUNT_W-1:0] in_count;
  logic [OWNER_W-1:0] in_owner;
  logic [PAGE_W-1:0]  in_page;
  op_t                in_op;
  logic               in_wr;
  logic               in_acc;

  assign in_frame  = in_tdata[8:0];
  assign in_count  = in_tdata[18:9];
  assign in_owner  = in_tdata[26:19];
  assign in_page   = in_tdata[46:27];
  assign in_op     = op_t'(in_tuser[1:0]);
  assign in_wr     = in_tuser[2];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // effective frame count: 0 acts as 1, clip at the table size
  logic [COUNT_W-1:0] eff_count;
  always_comb begin
    if (frame_count_r == '0) begin
      eff_count = COUNT_W'(1);
    end else if (frame_count_r > COUNT_W'(NUM_FRAMES)) begin
      eff_count = COUNT_W'(NUM_FRAMES);
    end else begin
      eff_count = frame_count_r;
    end
  end

  // shared clock-hand stepper: advance the walking address, wrap at the count
  logic [COUNT_W-1:0] addr_inc;
  logic [FRAME_W-1:0] addr_step;
  assign addr_inc  = {1'b0, addr_r} + COUNT_W'(1);
  assign addr_step = (addr_inc == n_r) ? '0 : addr_inc[FRAME_W-1:0];

  // victim chosen this cycle and the hand position one past it
  logic               fin;
  logic [FRAME_W-1:0] vic_frame;
  logic [OWNER_W-1:0] vic_owner;
  logic [PAGE_W-1:0]  vic_page;
  logic               vic_dirty;
  logic [COUNT_W-1:0] vic_inc;
  assign vic_inc = {1'b0, vic_frame} + COUNT_W'(1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    frame_count_nxt = frame_count_r;
    hand_nxt        = hand_r;
    op_nxt          = op_r;
    owner_nxt       = owner_r;
    page_nxt        = page_r;
    wr_nxt          = wr_r;
    addr_nxt        = addr_r;
    cnt_nxt         = cnt_r;
    n_nxt           = n_r;
    start_nxt       = start_r;
    tag_vld_nxt     = tag_vld_r;
    tag_addr_nxt    = tag_addr_r;
    c2_vld_nxt      = c2_vld_r;
    c2_frame_nxt    = c2_frame_r;
    c2_owner_nxt    = c2_owner_r;
    c2_page_nxt     = c2_page_r;
    c2_dirty_nxt    = c2_dirty_r;
    c3_vld_nxt      = c3_vld_r;
    c3_frame_nxt    = c3_frame_r;
    c3_owner_nxt    = c3_owner_r;
    c3_page_nxt     = c3_page_r;
    c3_dirty_nxt    = c3_dirty_r;
    res_found_nxt   = res_found_r;
    res_frame_nxt   = res_frame_r;
    res_owner_nxt   = res_owner_r;
    res_page_nxt    = res_page_r;
    res_dirty_nxt   = res_dirty_r;
    out_data_nxt    = out_data_r;
    out_user_nxt    = out_user_r;
    // drop the output once the consumer takes it
    out_vld_nxt     = out_vld_r && !out_tready;

    tbl_wr       = '0;
    tbl_wr.addr  = addr_r;
    tbl_wr.owner = owner_r;
    tbl_wr.page  = page_r;
    rd_addr      = addr_r;

    fin       = 1'b0;
    vic_frame = '0;
    vic_owner = '0;
    vic_page  = '0;
    vic_dirty = 1'b0;

    if (cfg_wr_en) begin
      frame_count_nxt = cfg_wr_data;
    end

    case (state_r)
      ST_CLEAR: begin
        // sweep every entry once after reset, clearing all marks
        tbl_wr.used_we  = 1'b1;
        tbl_wr.acc_we   = 1'b1;
        tbl_wr.dirty_we = 1'b1;
        if (addr_r == '1) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + FRAME_W'(1);
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_op;
          owner_nxt     = in_owner;
          page_nxt      = in_page;
          wr_nxt        = in_wr;
          addr_nxt      = in_frame;
          cnt_nxt       = in_count;
          res_found_nxt = 1'b0;
          res_frame_nxt = '0;
          res_owner_nxt = '0;
          res_page_nxt  = '0;
          res_dirty_nxt = 1'b0;
          case (in_op)
            OP_MAP, OP_UNMAP: begin
              state_nxt = (in_count == '0) ? ST_RESP : ST_RUN;
            end
            OP_REF: begin
              state_nxt = ST_REF;
            end
            OP_SELECT: begin
              // restart at frame 0 when the hand sits at or beyond the count
              n_nxt       = eff_count;
              start_nxt   = ({1'b0, hand_r} >= eff_count) ? '0 : hand_r;
              addr_nxt    = ({1'b0, hand_r} >= eff_count) ? '0 : hand_r;
              cnt_nxt     = '0;
              tag_vld_nxt = 1'b0;
              c2_vld_nxt  = 1'b0;
              c3_vld_nxt  = 1'b0;
              state_nxt   = ST_SCAN;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_RUN: begin
        // one frame of the map or unmap run per cycle
        tbl_wr.used_we = 1'b1;
        if (op_r == OP_MAP) begin
          tbl_wr.used_d   = 1'b1;
          tbl_wr.acc_we   = 1'b1;
          tbl_wr.dirty_we = 1'b1;
          tbl_wr.pay_we   = 1'b1;
        end
        if (cnt_r == COUNT_W'(1) || addr_r == '1) begin
          state_nxt = ST_RESP;
        end else begin
          addr_nxt = addr_r + FRAME_W'(1);
          cnt_nxt  = cnt_r - COUNT_W'(1);
        end
      end

      ST_REF: begin
        tbl_wr.acc_we   = 1'b1;
        tbl_wr.acc_d    = 1'b1;
        tbl_wr.dirty_we = wr_r;
        tbl_wr.dirty_d  = 1'b1;
        state_nxt       = ST_RESP;
      end

      ST_SCAN: begin
        // issue side: one read per cycle, walking from the hand
        if (cnt_r != n_r) begin
          tag_vld_nxt  = 1'b1;
          tag_addr_nxt = addr_r;
          addr_nxt     = addr_step;
          cnt_nxt      = cnt_r + COUNT_W'(1);
        end else begin
          tag_vld_nxt = 1'b0;
        end
        // evaluate side: data for tag_addr_r
        if (tag_vld_r) begin
          if (tbl_rd.used && !tbl_rd.acc && !tbl_rd.dirty) begin
            // clean, unreferenced frame: take it now
            fin       = 1'b1;
            vic_frame = tag_addr_r;
            vic_owner = tbl_rd.owner;
            vic_page  = tbl_rd.page;
            vic_dirty = 1'b0;
          end else begin
            if (!c2_vld_r && tbl_rd.used && !tbl_rd.acc) begin
              c2_vld_nxt   = 1'b1;
              c2_frame_nxt = tag_addr_r;
              c2_owner_nxt = tbl_rd.owner;
              c2_page_nxt  = tbl_rd.page;
              c2_dirty_nxt = tbl_rd.dirty;
            end
            if (!c3_vld_r && tbl_rd.used) begin
              c3_vld_nxt   = 1'b1;
              c3_frame_nxt = tag_addr_r;
              c3_owner_nxt = tbl_rd.owner;
              c3_page_nxt  = tbl_rd.page;
              c3_dirty_nxt = tbl_rd.dirty;
            end
          end
        end else if (cnt_r == n_r) begin
          // scan drained: empty table reports nothing, else start the clearing pass
          if (!c3_vld_r) begin
            state_nxt = ST_RESP;
          end else begin
            addr_nxt  = start_r;
            cnt_nxt   = '0;
            state_nxt = ST_SWEEP;
          end
        end
      end

      ST_SWEEP: begin
        // second pass: clear accessed marks up to the second-pass candidate, or over all frames
        // for the fallback; marks of empty frames never reach a result, so clear them blindly
        if (c2_vld_r && addr_r == c2_frame_r) begin
          fin       = 1'b1;
          vic_frame = c2_frame_r;
          vic_owner = c2_owner_r;
          vic_page  = c2_page_r;
          vic_dirty = c2_dirty_r;
        end else if (!c2_vld_r && cnt_r == n_r) begin
          fin       = 1'b1;
          vic_frame = c3_frame_r;
          vic_owner = c3_owner_r;
          vic_page  = c3_page_r;
          vic_dirty = c3_dirty_r;
        end else begin
          tbl_wr.acc_we = 1'b1;
          tbl_wr.acc_d  = 1'b0;
          addr_nxt      = addr_step;
          cnt_nxt       = cnt_r + COUNT_W'(1);
        end
      end

      ST_RESP: begin
        // hold the result until the output register is free
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_user_nxt = res_found_r;
          out_data_nxt = {2'b00, res_dirty_r, res_page_r, res_owner_r, res_frame_r};
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      res_found_nxt = 1'b1;
      res_frame_nxt = vic_frame;
      res_owner_nxt = vic_owner;
      res_page_nxt  = vic_page;
      res_dirty_nxt = vic_dirty;
      hand_nxt      = (vic_inc == n_r) ? '0 : vic_inc[FRAME_W-1:0];
      state_nxt     = ST_RESP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      frame_count_r <= COUNT_W'(FRAME_COUNT_RST);
      hand_r        <= '0;
      addr_r        <= '0;
      cnt_r         <= '0;
      tag_vld_r     <= 1'b0;
      c2_vld_r      <= 1'b0;
      c3_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      frame_count_r <= frame_count_nxt;
      hand_r        <= hand_nxt;
      addr_r        <= addr_nxt;
      cnt_r         <= cnt_nxt;
      tag_vld_r     <= tag_vld_nxt;
      c2_vld_r      <= c2_vld_nxt;
      c3_vld_r      <= c3_vld_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    owner_r     <= owner_nxt;
    page_r      <= page_nxt;
    wr_r        <= wr_nxt;
    n_r         <= n_nxt;
    start_r     <= start_nxt;
    tag_addr_r  <= tag_addr_nxt;
    c2_frame_r  <= c2_frame_nxt;
    c2_owner_r  <= c2_owner_nxt;
    c2_page_r   <= c2_page_nxt;
    c2_dirty_r  <= c2_dirty_nxt;
    c3_frame_r  <= c3_frame_nxt;
    c3_owner_r  <= c3_owner_nxt;
    c3_page_r   <= c3_page_nxt;
    c3_dirty_r  <= c3_dirty_nxt;
    res_found_r <= res_found_nxt;
    res_frame_r <= res_frame_nxt;
    res_owner_r <= res_owner_nxt;
    res_page_r  <= res_page_nxt;
    res_dirty_r <= res_dirty_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_user_r;

endmodule
